// File: design/lqnp_pkg.sv
`timescale 1ns / 1ps

package lqnp_pkg;

  // Operation codes carried in the request.
  typedef enum logic [1:0] {
    FN_TAKE   = 2'd0,
    FN_APPEND = 2'd1,
    FN_REMOVE = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Which result the datapath latches. RES_EMPTY also serves the unused operation code.
  typedef enum logic [2:0] {
    RES_EMPTY   = 3'd0,
    RES_RANGE   = 3'd1,
    RES_TAKE    = 3'd2,
    RES_ID_OK   = 3'd3,
    RES_ID_MISS = 3'd4
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_item;
    logic     init_step;
    logic     walk_start;
    logic     rd_cur;
    logic     take_upd;
    logic     app_link;
    logic     app_self;
    logic     walk_chk;
    logic     rem_fix;
    logic     rem_clr;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic  init_last;
    logic  core_bad;
    func_t func;
    logic  id_bad;
    logic  head_none;
    logic  cur_none;
    logic  steps_end;
    logic  match;
    logic  out_free;
  } sts_t;

endpackage

// File: design/linked_queue_node_pool.sv
`timescale 1ns / 1ps

// Linked queue node pool: per core, NODES service nodes kept on a free queue
// and a work queue, both threaded through one shared next-link memory.
// Input channel (in_*): one request per handshake with an operation (take head,
// append at tail, remove named node), a core, a queue and a node id.
// Output channel (out_*): exactly one result per request, in request order,
// with the node acted on and a status (ok, empty or not found, out of range).
// Requests are handled one at a time by a controller and a datapath around a
// link memory with one write port and a registered read port; that memory sets
// the pace. The result shows on out_tvalid from the output register, which the
// controller loads in its done state as soon as that register is free.
// After reset a clearing pass writes CORES * NODES links, one per cycle, while
// in_tready stays low; then every node is free in id order, work queues empty.
// A stalled receiver holds the result in the output register; the next request
// is still accepted and worked on, but its result waits until the slot frees.

module linked_queue_node_pool
  import lqnp_pkg::*;
#(
  parameter int NODES = 16,
  parameter int CORES = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // func[1:0], core_index[2], queue_select[3], node_id[11:4]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // node_out[3:0], status[5:4]
);

  cmd_t cmd;
  sts_t sts;

  lqnp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lqnp_dp #(
    .NODES (NODES),
    .CORES (CORES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: design/lqnp_ram.sv
`timescale 1ns / 1ps

module lqnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/lqnp_ctrl.sv
`timescale 1ns / 1ps

module lqnp_ctrl
  import lqnp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_TAKE_RD,
    S_TAKE_UPD,
    S_APP_LINK,
    S_APP_SELF,
    S_WALK_RD,
    S_WALK_CHK,
    S_REM_FIX,
    S_REM_CLR,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;

  // Next state and the command issued in each state.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.walk_start = 1'b1;
        if (sts.core_bad) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_RANGE;
          state_nxt    = S_DONE;
        end else begin
          case (sts.func)
            FN_TAKE: begin
              if (sts.head_none) begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_EMPTY;
                state_nxt    = S_DONE;
              end else begin
                state_nxt = S_TAKE_RD;
              end
            end
            FN_APPEND: begin
              if (sts.id_bad) begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_RANGE;
                state_nxt    = S_DONE;
              end else begin
                state_nxt = S_APP_LINK;
              end
            end
            FN_REMOVE: begin
              if (sts.id_bad) begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_RANGE;
                state_nxt    = S_DONE;
              end else begin
                state_nxt = S_WALK_RD;
              end
            end
            default: begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_EMPTY;
              state_nxt    = S_DONE;
            end
          endcase
        end
      end
      S_TAKE_RD: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_TAKE_UPD;
      end
      S_TAKE_UPD: begin
        cmd.take_upd = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_TAKE;
        state_nxt    = S_DONE;
      end
      S_APP_LINK: begin
        cmd.app_link = 1'b1;
        state_nxt    = S_APP_SELF;
      end
      S_APP_SELF: begin
        cmd.app_self = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_ID_OK;
        state_nxt    = S_DONE;
      end
      S_WALK_RD: begin
        // The walk ends at the end of the queue or after NODES visits.
        if (sts.cur_none || sts.steps_end) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_ID_MISS;
          state_nxt    = S_DONE;
        end else begin
          cmd.rd_cur = 1'b1;
          state_nxt  = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        cmd.walk_chk = 1'b1;
        state_nxt    = sts.match ? S_REM_FIX : S_WALK_RD;
      end
      S_REM_FIX: begin
        cmd.rem_fix = 1'b1;
        state_nxt   = S_REM_CLR;
      end
      S_REM_CLR: begin
        cmd.rem_clr  = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_ID_OK;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // State and registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_tready = in_tready_r;

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another was in progress");

  a_no_req_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !in_tready)
    else $error("request accepted during the link clearing pass");

  a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> in_tready)
    else $error("not ready after delivering a result");
`endif

endmodule

// File: design/lqnp_dp.sv
`timescale 1ns / 1ps

module lqnp_dp
  import lqnp_pkg::*;
#(
  parameter int NODES = 16,
  parameter int CORES = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata
);

  localparam int LW    = $clog2(NODES + 1);
  localparam int DEPTH = CORES * NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(CORES);
  localparam int QN    = 2 * CORES;
  localparam int QW    = $clog2(QN);
  localparam logic [LW-1:0] NONE = LW'(NODES);
  localparam logic [LW-1:0] LAST = LW'(NODES - 1);

  // Latched request.
  func_t         func_r;
  logic [CW-1:0] core_r;
  logic          core_bad_r;
  logic          qsel_r;
  logic [7:0]    id_r;

  // Queue ends, walk registers and clearing counters.
  logic [LW-1:0] head_r [QN];
  logic [LW-1:0] tail_r [QN];
  logic [LW-1:0] cur_r, prev_r, nxt_r, steps_r;
  logic [AW-1:0] init_r;
  logic [LW-1:0] inode_r;

  // Result staging and output register.
  logic [3:0] res_node_r;
  logic [1:0] res_status_r;
  logic       out_valid_r;
  logic [3:0] out_node_r;
  logic [1:0] out_status_r;

  logic [QW-1:0] q;
  logic [AW-1:0] base;
  logic [LW-1:0] id_node, head, tail, rnxt, rdata, wnode, wdata, init_data;
  logic [AW-1:0] waddr, raddr;
  logic          we, id_bad, match, out_free;

  function automatic logic [LW-1:0] link_of(input logic [LW-1:0] v);
    return (v >= NONE) ? NONE : v;
  endfunction

  assign q         = QW'({core_r, qsel_r});
  assign base      = AW'(core_r) * AW'(NODES);
  assign id_bad    = id_r >= 8'(NODES);
  assign id_node   = id_r[LW-1:0];
  assign head      = head_r[q];
  assign tail      = tail_r[q];
  assign rnxt      = link_of(rdata);
  assign match     = (cur_r == id_node);
  assign out_free  = !out_valid_r || out_tready;
  assign init_data = (inode_r == LAST) ? NONE : inode_r + 1'b1;

  // Request register.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r     <= func_t'(in_tdata[1:0]);
      core_r     <= CW'(in_tdata[2]);
      core_bad_r <= {7'd0, in_tdata[2]} >= 8'(CORES);
      qsel_r     <= in_tdata[3];
      id_r       <= in_tdata[11:4];
    end
  end

  // Link store write port: one link per cycle.
  always_comb begin
    we    = 1'b0;
    wnode = cur_r;
    wdata = NONE;
    if (cmd.init_step) begin
      we    = 1'b1;
      wdata = init_data;
    end else if (cmd.take_upd) begin
      we = (rnxt != NONE);
    end else if (cmd.app_link) begin
      we    = (tail != NONE);
      wnode = tail;
      wdata = id_node;
    end else if (cmd.app_self) begin
      we    = 1'b1;
      wnode = id_node;
    end else if (cmd.rem_fix) begin
      we    = (prev_r != NONE);
      wnode = prev_r;
      wdata = nxt_r;
    end else if (cmd.rem_clr) begin
      we = 1'b1;
    end
  end

  assign waddr = cmd.init_step ? init_r : base + AW'(wnode);
  assign raddr = base + AW'(cur_r);

  lqnp_ram #(
    .WIDTH (LW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_links (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_cur),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Clearing pass counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r  <= '0;
      inode_r <= '0;
    end else if (cmd.init_step) begin
      init_r  <= init_r + 1'b1;
      inode_r <= (inode_r == LAST) ? '0 : inode_r + 1'b1;
    end
  end

  // Queue heads and tails.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QN; i++) begin
        head_r[i] <= (i % 2 == 0) ? '0 : NONE;
        tail_r[i] <= (i % 2 == 0) ? LAST : NONE;
      end
    end else begin
      if (cmd.take_upd) begin
        head_r[q] <= rnxt;
        if (rnxt == NONE) begin
          tail_r[q] <= NONE;
        end
      end
      if (cmd.app_link && (tail == NONE)) begin
        head_r[q] <= id_node;
      end
      if (cmd.app_self) begin
        tail_r[q] <= id_node;
      end
      if (cmd.rem_fix) begin
        if (prev_r == NONE) begin
          head_r[q] <= nxt_r;
        end
        if (cur_r == tail) begin
          tail_r[q] <= prev_r;
        end
      end
    end
  end

  // Walk registers: current node, its predecessor and the visit count.
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      cur_r   <= head;
      prev_r  <= NONE;
      steps_r <= '0;
    end else if (cmd.walk_chk) begin
      nxt_r <= rnxt;
      if (!match) begin
        prev_r  <= cur_r;
        cur_r   <= rnxt;
        steps_r <= steps_r + 1'b1;
      end
    end
  end

  // Result staging.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        RES_RANGE: begin
          res_node_r   <= 4'd0;
          res_status_r <= ST_RANGE;
        end
        RES_TAKE: begin
          res_node_r   <= 4'(cur_r);
          res_status_r <= ST_OK;
        end
        RES_ID_OK: begin
          res_node_r   <= id_r[3:0];
          res_status_r <= ST_OK;
        end
        RES_ID_MISS: begin
          res_node_r   <= id_r[3:0];
          res_status_r <= ST_MISS;
        end
        default: begin
          res_node_r   <= 4'd0;
          res_status_r <= ST_MISS;
        end
      endcase
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_node_r   <= res_node_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_status_r, out_node_r};

  // Status to the controller.
  always_comb begin
    sts.init_last = (init_r == AW'(DEPTH - 1));
    sts.core_bad  = core_bad_r;
    sts.func      = func_r;
    sts.id_bad    = id_bad;
    sts.head_none = (head == NONE);
    sts.cur_none  = (cur_r == NONE);
    sts.steps_end = (steps_r == NONE);
    sts.match     = match;
    sts.out_free  = out_free;
  end

`ifndef ASSERT_OFF
  a_read_real_node: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_cur |-> (cur_r != NONE))
    else $error("link read issued for an absent node");

  a_unlink_target: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem_fix |-> (cur_r == id_node))
    else $error("unlink of a node other than the requested one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result overwritten before it was taken");
`endif

endmodule

// File: verif/linked_queue_node_pool_tb.sv
`timescale 1ns / 1ps

module linked_queue_node_pool_tb;
  import lqnp_pkg::*;

  localparam int NODES = 16;
  localparam int CORES = 2;
  localparam logic [4:0] NO_NODE = 5'(NODES);
  localparam int RANDOM_REQUESTS = 1150;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int REPORT_LIMIT = 10;

  // One result as it sits in out_tdata[5:0].
  typedef struct packed {
    logic [1:0] status;
    logic [3:0] node;
  } pool_result_t;

  // Mirror of the node pool: link store, queue ends, and the results still owed.
  class node_pool_scoreboard;
    logic [4:0]       next_link [CORES*NODES];
    logic [4:0]       q_head [CORES*2];
    logic [4:0]       q_tail [CORES*2];
    logic [NODES-1:0] held [CORES];
    pool_result_t     owed[$];
    int               errors;
    int               results_seen;
    int               op_count [4];
    int               status_count [3];

    function new();
      for (int c = 0; c < CORES; c++) begin
        for (int i = 0; i < NODES; i++) begin
          next_link[c*NODES+i] = (i + 1 < NODES) ? 5'(i + 1) : NO_NODE;
        end
        q_head[c*2]   = 5'd0;
        q_tail[c*2]   = 5'(NODES - 1);
        q_head[c*2+1] = NO_NODE;
        q_tail[c*2+1] = NO_NODE;
        held[c]       = '0;
      end
    endfunction

    // A link at or above NODES means the end of the chain.
    function logic [4:0] link_after(int base, logic [4:0] n);
      logic [4:0] v;
      v = next_link[base + int'(n)];
      return (int'(v) < NODES) ? v : NO_NODE;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Apply one accepted request to the mirror and queue up its result.
    function void note_request(logic [15:0] req);
      func_t        fn;
      int           core;
      int           q;
      int           base;
      int           id;
      int           steps;
      bit           found;
      logic [4:0]   h;
      logic [4:0]   t;
      logic [4:0]   cur;
      logic [4:0]   prev;
      pool_result_t r;
      fn   = func_t'(req[1:0]);
      core = int'(req[2]);
      q    = core * 2 + int'(req[3]);
      id   = int'(req[11:4]);
      base = core * NODES;
      op_count[int'(req[1:0])]++;
      case (fn)
        FN_TAKE: begin
          h = q_head[q];
          if (int'(h) >= NODES) begin
            r = '{status: ST_MISS, node: 4'd0};
          end else begin
            q_head[q] = link_after(base, h);
            if (q_head[q] == NO_NODE) q_tail[q] = NO_NODE;
            else next_link[base + int'(h)] = NO_NODE;
            held[core][h[3:0]] = 1'b1;
            r = '{status: ST_OK, node: h[3:0]};
          end
        end
        FN_APPEND: begin
          if (id >= NODES) begin
            r = '{status: ST_RANGE, node: 4'd0};
          end else begin
            t = q_tail[q];
            if (int'(t) >= NODES) q_head[q] = 5'(id);
            else next_link[base + int'(t)] = 5'(id);
            next_link[base + id] = NO_NODE;
            q_tail[q] = 5'(id);
            held[core][id] = 1'b0;
            r = '{status: ST_OK, node: 4'(id)};
          end
        end
        FN_REMOVE: begin
          if (id >= NODES) begin
            r = '{status: ST_RANGE, node: 4'd0};
          end else begin
            // Walk from the head, at most NODES hops, and unlink the first match.
            r     = '{status: ST_MISS, node: 4'(id)};
            cur   = q_head[q];
            prev  = NO_NODE;
            found = 1'b0;
            for (steps = 0; steps < NODES && int'(cur) < NODES && !found; steps++) begin
              if (int'(cur) == id) begin
                if (id == int'(q_head[q]) || int'(prev) >= NODES)
                  q_head[q] = link_after(base, cur);
                else
                  next_link[base + int'(prev)] = link_after(base, cur);
                if (cur == q_tail[q]) q_tail[q] = prev;
                next_link[base + int'(cur)] = NO_NODE;
                held[core][id] = 1'b1;
                r.status = ST_OK;
                found = 1'b1;
              end else begin
                prev = cur;
                cur  = link_after(base, cur);
              end
            end
          end
        end
        default: begin
          r = '{status: ST_MISS, node: 4'd0};
        end
      endcase
      owed.push_back(r);
    endfunction

    // Compare one delivered result with the oldest one owed.
    function void check_result(logic [7:0] data);
      pool_result_t got;
      pool_result_t want;
      got = pool_result_t'(data[5:0]);
      results_seen++;
      if (got.status <= ST_RANGE) status_count[got.status]++;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result with nothing outstanding: node %0d status %0d",
                   $time, got.node, got.status);
        return;
      end
      want = owed.pop_front();
      if (got.node !== want.node || got.status !== want.status) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result error: expected node %0d status %0d, got node %0d status %0d",
                   $time, want.node, want.status, got.node, got.status);
      end
    endfunction

    // A node this core has taken out and not yet put back, or -1.
    function int pick_held(int core);
      int pool[$];
      for (int i = 0; i < NODES; i++) begin
        if (held[core][i]) pool.push_back(i);
      end
      if (pool.size() == 0) return -1;
      return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    // A node currently reachable from the head of the queue, or -1.
    function int pick_queued(int core, int qsel);
      int         pool[$];
      logic [4:0] cur;
      cur = q_head[core*2 + qsel];
      for (int s = 0; s < NODES && int'(cur) < NODES; s++) begin
        pool.push_back(int'(cur));
        cur = link_after(core * NODES, cur);
      end
      if (pool.size() == 0) return -1;
      return pool[$urandom_range(0, pool.size() - 1)];
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // func[1:0], core_index[2], queue_select[3], node_id[11:4]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // node_out[3:0], status[5:4]

  node_pool_scoreboard pool_sb = new();
  bit calm = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  linked_queue_node_pool #(
    .NODES(NODES),
    .CORES(CORES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then long; none in calm stretches.
  function automatic int pick_gap(bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [15:0] pack_request(func_t fn, bit core, bit qsel, logic [7:0] id);
    return {4'b0000, id, qsel, core, fn};
  endfunction

  // Offer one request, wait for the handshake, then maybe leave a gap.
  task automatic send(logic [15:0] req);
    int gap;
    in_tdata  <= req;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pool_sb.note_request(req);
    gap = pick_gap(calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly coherent traffic: take, put a held node back, remove a queued node.
  function automatic logic [15:0] random_request();
    bit core;
    bit qsel;
    int roll;
    int n;
    core = 1'($urandom_range(0, 1));
    qsel = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      case ($urandom_range(0, 2))
        0: return pack_request(FN_TAKE, core, qsel, 8'($urandom_range(0, 255)));
        1: begin
          n = pool_sb.pick_held(int'(core));
          if (n < 0) return pack_request(FN_TAKE, core, 1'b0, 8'd0);
          return pack_request(FN_APPEND, core, qsel, 8'(n));
        end
        default: begin
          n = pool_sb.pick_queued(int'(core), int'(qsel));
          if (n < 0) return pack_request(FN_TAKE, core, ~qsel, 8'd0);
          return pack_request(FN_REMOVE, core, qsel, 8'(n));
        end
      endcase
    end
    // Noise: any operation code, any id including out of range ones.
    return pack_request(func_t'($urandom_range(0, 3)), core, qsel,
                        ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 15)));
  endfunction

  // Receiver: check each delivered result and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) pool_sb.check_result(out_tdata);
    if (stall_left > 0) stall_left = stall_left - 1;
    else stall_left = pick_gap(calm);
    out_tready <= (stall_left == 0);
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("linked_queue_node_pool: mismatch");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty take, out of range ids, absent node, head, middle and tail removal.
    send(pack_request(FN_TAKE,   1'b0, 1'b1, 8'd0));
    send(pack_request(FN_TAKE,   1'b0, 1'b0, 8'd0));
    send(pack_request(FN_APPEND, 1'b0, 1'b1, 8'd0));
    send(pack_request(FN_APPEND, 1'b0, 1'b1, 8'hFF));
    send(pack_request(FN_APPEND, 1'b0, 1'b1, 8'd16));
    send(pack_request(FN_REMOVE, 1'b0, 1'b1, 8'hC8));
    send(pack_request(FN_REMOVE, 1'b0, 1'b1, 8'd5));
    send(pack_request(FN_TAKE,   1'b0, 1'b0, 8'd0));
    send(pack_request(FN_APPEND, 1'b0, 1'b1, 8'd1));
    send(pack_request(FN_TAKE,   1'b0, 1'b0, 8'd0));
    send(pack_request(FN_APPEND, 1'b0, 1'b1, 8'd2));
    send(pack_request(FN_REMOVE, 1'b0, 1'b1, 8'd1));
    send(pack_request(FN_REMOVE, 1'b0, 1'b1, 8'd2));
    send(pack_request(FN_REMOVE, 1'b0, 1'b1, 8'd0));
    // Take that leaves the queue empty, then take on the empty queue.
    send(pack_request(FN_APPEND, 1'b0, 1'b1, 8'd0));
    send(pack_request(FN_TAKE,   1'b0, 1'b1, 8'd0));
    send(pack_request(FN_TAKE,   1'b0, 1'b1, 8'd0));
    send(pack_request(FN_NOP,    1'b1, 1'b0, 8'hAA));
    // Appending the same node twice makes a self loop; the walk must stop at its bound.
    send(pack_request(FN_TAKE,   1'b1, 1'b0, 8'd0));
    send(pack_request(FN_APPEND, 1'b1, 1'b1, 8'd0));
    send(pack_request(FN_APPEND, 1'b1, 1'b1, 8'd0));
    send(pack_request(FN_REMOVE, 1'b1, 1'b1, 8'd8));
    send(pack_request(FN_REMOVE, 1'b1, 1'b1, 8'd0));
    send(pack_request(FN_TAKE,   1'b1, 1'b1, 8'd0));
    send(pack_request(FN_REMOVE, 1'b1, 1'b0, 8'd15));

    // Random traffic, with calm stretches and one full drain halfway through.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_REQUESTS / 2 && pool_sb.pending() > 0) begin
        in_tvalid <= 1'b0;
        while (pool_sb.pending() > 0) @(posedge clk);
      end
      send(random_request());
    end
    in_tvalid <= 1'b0;

    // Wait for every owed result, then watch for strays.
    while (pool_sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Requests: %0d take, %0d append, %0d remove, %0d unused code.",
             pool_sb.op_count[0], pool_sb.op_count[1], pool_sb.op_count[2],
             pool_sb.op_count[3]);
    $display("Results: %0d checked (%0d ok, %0d empty or absent, %0d out of range), %0d errors.",
             pool_sb.results_seen, pool_sb.status_count[0], pool_sb.status_count[1],
             pool_sb.status_count[2], pool_sb.errors);
    if (pool_sb.errors == 0 && pool_sb.pending() == 0) begin
      $display("linked_queue_node_pool: match");
    end else begin
      $display("linked_queue_node_pool: mismatch");
    end
    $finish;
  end

endmodule
